// ===== rtl/core/nfp_pkg.sv =====
// ----------------------------------------------------------------------------
// nfp_pkg: shared types for the Newton fractal pixel engine
// Sequencer states, register indexes, root codes and divider status.
// ----------------------------------------------------------------------------
package nfp_pkg;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_ITER   = 2'd0,
      CSR_SHADE_STEP = 2'd1,
      CSR_TOLERANCE  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ROOT_NONE  = 2'd0,
      ROOT_ONE   = 2'd1,
      ROOT_UPPER = 2'd2,
      ROOT_LOWER = 2'd3
   } root_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TOL0, ST_TOL1, ST_RX, ST_RY, ST_RC,
      ST_M0, ST_M1, ST_M2, ST_DX, ST_DY,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_U0, ST_U1, ST_U2,
      ST_SHADE, ST_DONE
   } nfp_state_type;

   typedef struct packed {
      logic busy;
      logic ovf;
   } div_stat_type;

endpackage

// ===== rtl/core/nfp_req_if.sv =====
// ----------------------------------------------------------------------------
// nfp_req_if: start point channel
// Valid/ready channel carrying one complex start point per beat.
// ----------------------------------------------------------------------------
interface nfp_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_re;
   logic signed [COORD_WIDTH-1:0] start_im;

   modport source (output valid, output start_re, output start_im, input ready);
   modport sink (input valid, input start_re, input start_im, output ready);
endinterface

// ===== rtl/core/nfp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nfp_rsp_if: pixel result channel
// Valid/ready channel carrying one pixel result per beat.
// ----------------------------------------------------------------------------
interface nfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] root_found;
   logic [7:0] shade;
   logic [7:0] iterations;
   logic       saturated;

   modport source (output valid, output root_found, output shade, output iterations,
                   output saturated, input ready);
   modport sink (input valid, input root_found, input shade, input iterations,
                 input saturated, output ready);
endinterface

// ===== rtl/core/nfp_div.sv =====
// ----------------------------------------------------------------------------
// nfp_div: restoring divider, one quotient bit per cycle
// Computes floor((num << SH) / den) over QB bits and flags a quotient that
// does not fit in QB bits.
// ----------------------------------------------------------------------------
module nfp_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 64,
   parameter int QB    = 34,
   parameter int SH    = 57
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [QB-1:0]        quo,
   output nfp_pkg::div_stat_type stat
);

   localparam int DW   = NUM_W + SH;
   localparam int TW   = DW - QB;
   localparam int CMPW = (TW > DEN_W) ? TW : DEN_W;
   localparam int CNTW = $clog2(QB + 1);

   logic [DW-1:0]    dvd;
   logic [CMPW-1:0]  top_ext;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   logic [DEN_W-1:0] rem_ff;
   logic [QB-1:0]    low_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNTW-1:0]  cnt_ff;
   logic             ovf_ff;

   assign dvd     = DW'(num) << SH;
   assign top_ext = CMPW'(dvd[DW-1:QB]);
   assign trial   = {rem_ff, low_ff[QB-1]};
   assign diff    = trial - {1'b0, den_ff};
   assign ge      = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNTW'(QB);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         low_ff <= dvd[QB-1:0];
         rem_ff <= top_ext[DEN_W-1:0];
         ovf_ff <= top_ext >= CMPW'(den);
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_ff <= {low_ff[QB-2:0], ge};
      end
   end

   assign quo       = low_ff;
   assign stat.busy = cnt_ff != '0;
   assign stat.ovf  = ovf_ff;

endmodule

// ===== rtl/core/newton_fractal_pixel.sv =====
// ----------------------------------------------------------------------------
// newton_fractal_pixel: Newton iteration for z^3 - 1 on one start point
// Runs up to n Newton steps (n up to 255) between acceptance and the result beat;
// each step uses the bit-serial divider for two quotients of COORD_WIDTH + 2 bits,
// and the three roots are tested before each step and after the last. One point at
// a time: the next point is taken in the idle state after the current one has reached
// its result register. Reset is synchronous and active high: it idles the sequencer,
// empties the result register and restores the register defaults (limit 255, shade
// step 15, tolerance 26844).
// ----------------------------------------------------------------------------
module newton_fractal_pixel #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [nfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [FRAC_BITS:0]                csr_wdata,
   nfp_req_if.sink                           req_bus,
   nfp_rsp_if.source                         rsp_bus
);

   // Widths follow from the coordinate format. Distances to a root need one
   // bit more than a coordinate, so the shared multiplier is W+1 bits square.
   localparam int W     = COORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int MW    = W + 1;
   localparam int PW    = 2 * MW;
   localparam int QB    = W + 2;
   localparam int DEN_W = 2 * W;
   localparam int CLW   = 2 * W + 4;

   // Division by three is a multiplication by the rounded-up reciprocal,
   // exact for every dividend below 2^(W+1).
   localparam logic [MW-1:0] RECIP = MW'(((128'd1 << (W + 2)) + 128'd2) / 128'd3);

   // sqrt(3)/2 rounded to nearest, worked out bit by bit at elaboration.
   function automatic logic [W-1:0] calc_root_im();
      logic [127:0] target;
      logic [127:0] q;
      logic [127:0] t;
      target = 128'd3 << (2 * F - 2);
      q      = '0;
      for (int b = F; b >= 0; b--) begin
         t = q | (128'd1 << b);
         if (t * t <= target) begin
            q = t;
         end
      end
      if ((2 * q + 1) * (2 * q + 1) <= (128'd3 << (2 * F))) begin
         q = q + 128'd1;
      end
      return q[W-1:0];
   endfunction

   localparam logic [W-1:0]        ROOT_IM = calc_root_im();
   localparam logic signed [W+1:0] RE_ONE  = (W + 2)'(1) << F;
   localparam logic signed [W+1:0] RE_HALF = -((W + 2)'(1) << (F - 1));
   localparam logic signed [W+1:0] IM_ROOT = (W + 2)'(ROOT_IM);

   // Clamp a sign and magnitude to the coordinate range; the top bit of the
   // result reports that clamping happened.
   function automatic logic [W:0] sat_clamp(input logic neg, input logic [CLW-1:0] mag);
      logic [CLW-1:0] lim;
      logic           ovr;
      logic [W-1:0]   v;
      lim = (CLW'(1) << (W - 1)) - (neg ? CLW'(0) : CLW'(1));
      ovr = mag > lim;
      v   = ovr ? lim[W-1:0] : mag[W-1:0];
      if (neg) begin
         v = -v;
      end
      return {ovr, v};
   endfunction

   // Registers
   nfp_pkg::nfp_state_type state_ff, state_in;
   logic [7:0]             max_it_ff;
   logic [7:0]             step_ff;
   logic [F:0]             tol_ff;

   logic signed [W-1:0]    x_ff, y_ff, p_ff, q_ff, re2_ff, im2_ff;
   logic [PW-1:0]          prod_ff, acc_ff, tol2_ff, pp_ff, qq_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [7:0]             cnt_ff;
   nfp_pkg::root_type      idx_ff, found_ff;
   logic                   sat_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_root_ff;
   logic [7:0]             rsp_shade_ff, rsp_iter_ff;
   logic                   rsp_sat_ff;

   // Datapath signals
   logic [MW-1:0]          mul_a, mul_b;
   logic                   div_start;
   logic [W-1:0]           div_num;
   logic [DEN_W-1:0]       div_den;
   logic [QB-1:0]          div_quo;
   nfp_pkg::div_stat_type  div_stat;

   logic                   req_take, rsp_load;
   logic signed [W+1:0]    root_re, root_im, dx, dy, sx, sy;
   logic [W+1:0]           dxa, dya, sxa, sya;
   logic [PW:0]            d2;
   logic                   hit, z_zero;
   logic [W-1:0]           ax, ay, pm, qm;
   logic [DEN_W-1:0]       den_now;
   logic [QB:0]            qsum;
   logic [W:0]             quo_clamped;
   logic                   re_neg;
   logic [PW-1:0]          re_mag;
   logic [W:0]             re2_c, im2_c, third_c;

   nfp_div #(
      .NUM_W (W),
      .DEN_W (DEN_W),
      .QB    (QB),
      .SH    (2 * F + 1)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_load = (state_ff == nfp_pkg::ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // Distance of z to the root under test.
   always_comb begin
      root_re = (idx_ff == nfp_pkg::ROOT_ONE) ? RE_ONE : RE_HALF;
      case (idx_ff)
         nfp_pkg::ROOT_UPPER: root_im = IM_ROOT;
         nfp_pkg::ROOT_LOWER: root_im = -IM_ROOT;
         default:             root_im = '0;
      endcase
   end

   assign dx  = (W + 2)'(x_ff) - root_re;
   assign dy  = (W + 2)'(y_ff) - root_im;
   assign dxa = dx[W+1] ? (W + 2)'(-dx) : (W + 2)'(dx);
   assign dya = dy[W+1] ? (W + 2)'(-dy) : (W + 2)'(dy);
   assign d2  = (PW + 1)'(acc_ff) + (PW + 1)'(prod_ff);
   assign hit = d2 < (PW + 1)'(tol2_ff);

   assign z_zero  = (x_ff == '0) && (y_ff == '0);
   assign ax      = x_ff[W-1] ? W'(-x_ff) : W'(x_ff);
   assign ay      = y_ff[W-1] ? W'(-y_ff) : W'(y_ff);
   assign pm      = p_ff[W-1] ? W'(-p_ff) : W'(p_ff);
   assign qm      = q_ff[W-1] ? W'(-q_ff) : W'(q_ff);
   assign den_now = DEN_W'(acc_ff + prod_ff);

   // Quotient rounded half up, then clamped; a divider overflow sets the saturation flag.
   assign qsum        = {1'b0, div_quo} + (QB + 1)'(1);
   assign quo_clamped = sat_clamp((state_ff == nfp_pkg::ST_DX) ? x_ff[W-1] : !y_ff[W-1],
                                  CLW'(qsum[QB:1]));

   // Real part of (1/z)^2 is p^2 - q^2, imaginary part 2pq; both rounded.
   assign re_neg = pp_ff < qq_ff;
   assign re_mag = re_neg ? (qq_ff - pp_ff) : (pp_ff - qq_ff);
   assign re2_c  = sat_clamp(re_neg, (CLW'(re_mag) + (CLW'(1) << (F - 1))) >> F);
   assign im2_c  = sat_clamp(p_ff[W-1] ^ q_ff[W-1],
                             ((CLW'(prod_ff) << 1) + (CLW'(1) << (F - 1))) >> F);

   // 2z + (1/z)^2 before the division by three.
   assign sx  = ((W + 2)'(x_ff) <<< 1) + (W + 2)'(re2_ff);
   assign sy  = ((W + 2)'(y_ff) <<< 1) + (W + 2)'(im2_ff);
   assign sxa = sx[W+1] ? (W + 2)'(-sx) : (W + 2)'(sx);
   assign sya = sy[W+1] ? (W + 2)'(-sy) : (W + 2)'(sy);
   assign third_c = sat_clamp((state_ff == nfp_pkg::ST_U1) ? sx[W+1] : sy[W+1],
                              CLW'(prod_ff >> (W + 2)));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nfp_pkg::ST_IDLE:  if (req_take) state_in = nfp_pkg::ST_TOL0;
         nfp_pkg::ST_TOL0:  state_in = nfp_pkg::ST_TOL1;
         nfp_pkg::ST_TOL1:  state_in = nfp_pkg::ST_RX;
         nfp_pkg::ST_RX:    state_in = nfp_pkg::ST_RY;
         nfp_pkg::ST_RY:    state_in = nfp_pkg::ST_RC;
         nfp_pkg::ST_RC: begin
            if (hit) begin
               state_in = nfp_pkg::ST_SHADE;
            end else if (idx_ff != nfp_pkg::ROOT_LOWER) begin
               state_in = nfp_pkg::ST_RX;
            end else if (cnt_ff == max_it_ff) begin
               state_in = nfp_pkg::ST_SHADE;
            end else if (z_zero) begin
               state_in = nfp_pkg::ST_RX;
            end else begin
               state_in = nfp_pkg::ST_M0;
            end
         end
         nfp_pkg::ST_M0:    state_in = nfp_pkg::ST_M1;
         nfp_pkg::ST_M1:    state_in = nfp_pkg::ST_M2;
         nfp_pkg::ST_M2:    state_in = nfp_pkg::ST_DX;
         nfp_pkg::ST_DX:    if (!div_stat.busy) state_in = nfp_pkg::ST_DY;
         nfp_pkg::ST_DY:    if (!div_stat.busy) state_in = nfp_pkg::ST_P0;
         nfp_pkg::ST_P0:    state_in = nfp_pkg::ST_P1;
         nfp_pkg::ST_P1:    state_in = nfp_pkg::ST_P2;
         nfp_pkg::ST_P2:    state_in = nfp_pkg::ST_P3;
         nfp_pkg::ST_P3:    state_in = nfp_pkg::ST_U0;
         nfp_pkg::ST_U0:    state_in = nfp_pkg::ST_U1;
         nfp_pkg::ST_U1:    state_in = nfp_pkg::ST_U2;
         nfp_pkg::ST_U2:    state_in = nfp_pkg::ST_RX;
         nfp_pkg::ST_SHADE: state_in = nfp_pkg::ST_DONE;
         nfp_pkg::ST_DONE:  if (rsp_load) state_in = nfp_pkg::ST_IDLE;
         default:           state_in = nfp_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: multiplier operands and divider launches. In the other
   // states the multiplier forms count times shade step, which the result uses.
   always_comb begin
      mul_a     = MW'(cnt_ff);
      mul_b     = MW'(step_ff);
      div_start = 1'b0;
      div_num   = ax;
      div_den   = den_now;
      unique case (state_ff)
         nfp_pkg::ST_TOL0: begin
            mul_a = MW'(tol_ff);
            mul_b = MW'(tol_ff);
         end
         nfp_pkg::ST_RX: begin
            mul_a = dxa[MW-1:0];
            mul_b = dxa[MW-1:0];
         end
         nfp_pkg::ST_RY: begin
            mul_a = dya[MW-1:0];
            mul_b = dya[MW-1:0];
         end
         nfp_pkg::ST_M0: begin
            mul_a = MW'(ax);
            mul_b = MW'(ax);
         end
         nfp_pkg::ST_M1: begin
            mul_a = MW'(ay);
            mul_b = MW'(ay);
         end
         nfp_pkg::ST_M2: begin
            div_start = 1'b1;
         end
         nfp_pkg::ST_DX: begin
            div_start = !div_stat.busy;
            div_num   = ay;
            div_den   = den_ff;
         end
         nfp_pkg::ST_P0: begin
            mul_a = MW'(pm);
            mul_b = MW'(pm);
         end
         nfp_pkg::ST_P1: begin
            mul_a = MW'(qm);
            mul_b = MW'(qm);
         end
         nfp_pkg::ST_P2: begin
            mul_a = MW'(pm);
            mul_b = MW'(qm);
         end
         nfp_pkg::ST_U0: begin
            mul_a = MW'(sxa + (W + 2)'(1));
            mul_b = RECIP;
         end
         nfp_pkg::ST_U1: begin
            mul_a = MW'(sya + (W + 2)'(1));
            mul_b = RECIP;
         end
         default: ;
      endcase
   end

   assign req_bus.ready = state_ff == nfp_pkg::ST_IDLE;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_it_ff <= 8'd255;
         step_ff   <= 8'd15;
         tol_ff    <= (F + 1)'(26844);
      end else if (csr_we) begin
         unique case (csr_index)
            nfp_pkg::CSR_MAX_ITER:   max_it_ff <= csr_wdata[7:0];
            nfp_pkg::CSR_SHADE_STEP: step_ff   <= csr_wdata[7:0];
            nfp_pkg::CSR_TOLERANCE:  tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
      case (state_ff)
         nfp_pkg::ST_IDLE: begin
            if (req_take) begin
               x_ff   <= req_bus.start_re;
               y_ff   <= req_bus.start_im;
               cnt_ff <= '0;
               sat_ff <= 1'b0;
            end
         end
         nfp_pkg::ST_TOL1: begin
            tol2_ff <= prod_ff;
            idx_ff  <= nfp_pkg::ROOT_ONE;
         end
         nfp_pkg::ST_RY: acc_ff <= prod_ff;
         nfp_pkg::ST_RC: begin
            found_ff <= hit ? idx_ff : nfp_pkg::ROOT_NONE;
            if (!hit && idx_ff != nfp_pkg::ROOT_LOWER) begin
               idx_ff <= nfp_pkg::root_type'(idx_ff + 2'd1);
            end else if (!hit && cnt_ff != max_it_ff && z_zero) begin
               // A zero point takes no step but the step is counted.
               cnt_ff <= cnt_ff + 8'd1;
               idx_ff <= nfp_pkg::ROOT_ONE;
            end
         end
         nfp_pkg::ST_M1: acc_ff <= prod_ff;
         nfp_pkg::ST_M2: den_ff <= den_now;
         nfp_pkg::ST_DX: begin
            if (!div_stat.busy) begin
               p_ff   <= quo_clamped[W-1:0];
               sat_ff <= sat_ff | quo_clamped[W] | div_stat.ovf;
            end
         end
         nfp_pkg::ST_DY: begin
            if (!div_stat.busy) begin
               q_ff   <= quo_clamped[W-1:0];
               sat_ff <= sat_ff | quo_clamped[W] | div_stat.ovf;
            end
         end
         nfp_pkg::ST_P1: pp_ff <= prod_ff;
         nfp_pkg::ST_P2: qq_ff <= prod_ff;
         nfp_pkg::ST_P3: begin
            re2_ff <= re2_c[W-1:0];
            im2_ff <= im2_c[W-1:0];
            sat_ff <= sat_ff | re2_c[W] | im2_c[W];
         end
         nfp_pkg::ST_U1: begin
            x_ff   <= third_c[W-1:0];
            sat_ff <= sat_ff | third_c[W];
         end
         nfp_pkg::ST_U2: begin
            y_ff   <= third_c[W-1:0];
            sat_ff <= sat_ff | third_c[W];
            cnt_ff <= cnt_ff + 8'd1;
            idx_ff <= nfp_pkg::ROOT_ONE;
         end
         default: ;
      endcase
   end

   // Result register; the product here is count times shade step.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_root_ff  <= found_ff;
         rsp_shade_ff <= 8'd255 - prod_ff[7:0];
         rsp_iter_ff  <= cnt_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.root_found = rsp_root_ff;
   assign rsp_bus.shade      = rsp_shade_ff;
   assign rsp_bus.iterations = rsp_iter_ff;
   assign rsp_bus.saturated  = rsp_sat_ff;

   // The divider only runs while the sequencer waits on it.
   assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == nfp_pkg::ST_DX || state_ff == nfp_pkg::ST_DY))
      else $error("divider busy outside a divide state");

   // An accepted point always starts with the tolerance square.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == nfp_pkg::ST_TOL0)
      else $error("accepted point did not start the sequence");

   // A finished point with an empty result register is shown next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfp_pkg::ST_DONE && !rsp_valid_ff)
         |=> (rsp_valid_ff && state_ff == nfp_pkg::ST_IDLE))
      else $error("finished point not presented");

endmodule
